/* rtl/i2cram_pkg.sv */
// Shared types and constants for the I2C register access master.
`default_nettype none

package i2cram_pkg;

  // Operation codes carried by the input item
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Sequencer phases, held in the upper bits of the step index
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_START   = 4'd1;
  localparam logic [3:0] PH_ADDRW   = 4'd2;
  localparam logic [3:0] PH_REG     = 4'd3;
  localparam logic [3:0] PH_DATA    = 4'd4;
  localparam logic [3:0] PH_RESTART = 4'd5;
  localparam logic [3:0] PH_ADDRR   = 4'd6;
  localparam logic [3:0] PH_PREP    = 4'd7;
  localparam logic [3:0] PH_RECV    = 4'd8;
  localparam logic [3:0] PH_STOP    = 4'd9;

  // Sub-steps within a phase
  localparam logic [1:0] SUB_0 = 2'd0;
  localparam logic [1:0] SUB_1 = 2'd1;
  localparam logic [1:0] SUB_2 = 2'd2;
  localparam logic [1:0] SUB_3 = 2'd3;

  localparam logic [6:0] ADDR_RESET  = 7'h68;
  localparam logic [3:0] BITS_IN_BYTE = 4'd8;

  // Sequencer state
  typedef struct packed {
    logic [5:0] step_index;
    logic [3:0] bit_index;
    logic [7:0] shift_byte;
    logic       ack_good;
    logic       is_read;
    logic [7:0] saved_reg;
    logic [7:0] saved_data;
    logic [1:0] line_drive;   // bit 0 SCL low, bit 1 SDA low
  } seq_state_t;

  // One result item
  typedef struct packed {
    logic [7:0] read_data;
    logic       ack_ok;
    logic       done_res;
    logic       busy_res;
    logic       sda_pull_low;
    logic       scl_pull_low;
  } result_t;

endpackage

`default_nettype wire

/* rtl/i2cram_seq.sv */
// Bus step sequencer: state registers and the one-step next-state logic.
`default_nettype none

module i2cram_seq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire logic [1:0]          operation,
  input  wire logic [7:0]          reg_addr,
  input  wire logic [7:0]          write_data,
  input  wire logic                sda_level,
  input  wire logic [6:0]          device_address,
  output i2cram_pkg::result_t      res
);
  import i2cram_pkg::*;

  seq_state_t st;
  seq_state_t st_next;
  seq_state_t pre;
  logic       go;
  logic       done;
  logic [3:0] phase;
  logic [1:0] sub;
  logic [7:0] addr_byte;

  assign phase     = pre.step_index[5:2];
  assign sub       = pre.step_index[1:0];
  assign addr_byte = {device_address, 1'b0};

  // Latch a new transaction when idle, then run one bus step
  always_comb begin
    pre = st;
    go  = 1'b0;
    if (st.step_index == '0) begin
      if (operation == OP_WRITE || operation == OP_READ) begin
        pre.is_read    = (operation == OP_READ);
        pre.saved_reg  = reg_addr;
        pre.saved_data = write_data;
        pre.ack_good   = 1'b1;
        pre.step_index = {PH_START, SUB_0};
        pre.bit_index  = '0;
        go             = 1'b1;
      end
    end else begin
      go = 1'b1;
    end

    st_next = pre;
    done    = 1'b0;
    if (go) begin
      case (phase)
        PH_START, PH_RESTART: begin
          case (sub)
            SUB_0: begin
              st_next.line_drive[1] = 1'b0;
              st_next.step_index    = pre.step_index + 6'd1;
            end
            SUB_1: begin
              st_next.line_drive[0] = 1'b0;
              st_next.step_index    = pre.step_index + 6'd1;
            end
            SUB_2: begin
              st_next.line_drive[1] = 1'b1;
              st_next.step_index    = pre.step_index + 6'd1;
            end
            default: begin
              st_next.line_drive[0] = 1'b1;
              st_next.bit_index     = '0;
              if (phase == PH_START) begin
                st_next.shift_byte = addr_byte;
                st_next.step_index = {PH_ADDRW, SUB_0};
              end else begin
                st_next.shift_byte = addr_byte | 8'h01;
                st_next.step_index = {PH_ADDRR, SUB_0};
              end
            end
          endcase
        end

        PH_ADDRW, PH_REG, PH_DATA, PH_ADDRR: begin
          if (pre.bit_index < BITS_IN_BYTE) begin
            case (sub)
              SUB_0: begin
                st_next.line_drive[1] = ~pre.shift_byte[7];
                st_next.step_index    = pre.step_index + 6'd1;
              end
              SUB_1: begin
                st_next.line_drive[0] = 1'b0;
                st_next.step_index    = pre.step_index + 6'd1;
              end
              SUB_2: begin
                st_next.line_drive[0] = 1'b1;
                st_next.shift_byte    = {pre.shift_byte[6:0], 1'b0};
                st_next.bit_index     = pre.bit_index + 4'd1;
                st_next.step_index    = pre.step_index & 6'h3C;
              end
              default: begin
                st_next.step_index = '0;
                st_next.bit_index  = '0;
                st_next.line_drive = '0;
              end
            endcase
          end else if (pre.bit_index != BITS_IN_BYTE) begin
            st_next.step_index = '0;
            st_next.bit_index  = '0;
            st_next.line_drive = '0;
          end else begin
            // Acknowledge slot
            case (sub)
              SUB_0: begin
                st_next.line_drive[1] = 1'b0;
                st_next.step_index    = pre.step_index + 6'd1;
              end
              SUB_1: begin
                st_next.line_drive[0] = 1'b0;
                st_next.step_index    = pre.step_index + 6'd1;
              end
              SUB_2: begin
                st_next.line_drive[1] = 1'b0;
                if (sda_level) st_next.ack_good = 1'b0;
                st_next.step_index = pre.step_index + 6'd1;
              end
              default: begin
                st_next.line_drive[0] = 1'b1;
                st_next.bit_index     = '0;
                if (!pre.ack_good) begin
                  st_next.step_index = {PH_STOP, SUB_0};
                end else if (phase == PH_ADDRW) begin
                  st_next.shift_byte = pre.saved_reg;
                  st_next.step_index = {PH_REG, SUB_0};
                end else if (phase == PH_REG) begin
                  if (pre.is_read) begin
                    st_next.step_index = {PH_RESTART, SUB_0};
                  end else begin
                    st_next.shift_byte = pre.saved_data;
                    st_next.step_index = {PH_DATA, SUB_0};
                  end
                end else if (phase == PH_ADDRR) begin
                  st_next.step_index = {PH_PREP, SUB_0};
                end else begin
                  st_next.step_index = {PH_STOP, SUB_0};
                end
              end
            endcase
          end
        end

        PH_PREP: begin
          if (sub != SUB_0) begin
            st_next.step_index = '0;
            st_next.bit_index  = '0;
            st_next.line_drive = '0;
          end else begin
            st_next.line_drive[1] = 1'b0;
            st_next.shift_byte    = '0;
            st_next.step_index    = {PH_RECV, SUB_0};
            st_next.bit_index     = '0;
          end
        end

        PH_RECV: begin
          if (pre.bit_index < BITS_IN_BYTE) begin
            case (sub)
              SUB_0: begin
                st_next.line_drive[0] = 1'b0;
                st_next.step_index    = pre.step_index + 6'd1;
              end
              SUB_1: begin
                st_next.line_drive[1] = 1'b0;
                st_next.shift_byte    = {pre.shift_byte[6:0], sda_level};
                st_next.step_index    = pre.step_index + 6'd1;
              end
              SUB_2: begin
                st_next.line_drive[0] = 1'b1;
                st_next.bit_index     = pre.bit_index + 4'd1;
                st_next.step_index    = pre.step_index & 6'h3C;
              end
              default: begin
                st_next.step_index = '0;
                st_next.bit_index  = '0;
                st_next.line_drive = '0;
              end
            endcase
          end else if (pre.bit_index != BITS_IN_BYTE) begin
            st_next.step_index = '0;
            st_next.bit_index  = '0;
            st_next.line_drive = '0;
          end else begin
            // NACK slot
            case (sub)
              SUB_0: begin
                st_next.line_drive[1] = 1'b0;
                st_next.step_index    = pre.step_index + 6'd1;
              end
              SUB_1: begin
                st_next.line_drive[0] = 1'b0;
                st_next.step_index    = pre.step_index + 6'd1;
              end
              SUB_2: begin
                st_next.line_drive[0] = 1'b1;
                st_next.step_index    = pre.step_index + 6'd1;
              end
              default: begin
                st_next.line_drive[1] = 1'b0;
                st_next.step_index    = {PH_STOP, SUB_0};
                st_next.bit_index     = '0;
              end
            endcase
          end
        end

        PH_STOP: begin
          case (sub)
            SUB_0: begin
              st_next.line_drive[1] = 1'b1;
              st_next.step_index    = pre.step_index + 6'd1;
            end
            SUB_1: begin
              st_next.line_drive[0] = 1'b0;
              st_next.step_index    = pre.step_index + 6'd1;
            end
            SUB_2: begin
              st_next.line_drive[1] = 1'b0;
              st_next.step_index    = '0;
              st_next.bit_index     = '0;
              done                  = 1'b1;
            end
            default: begin
              st_next.step_index = '0;
              st_next.bit_index  = '0;
              st_next.line_drive = '0;
            end
          endcase
        end

        default: begin
          st_next.step_index = '0;
          st_next.bit_index  = '0;
          st_next.line_drive = '0;
        end
      endcase
    end
  end

  // Form the result item from the stepped state
  always_comb begin
    res.scl_pull_low = st_next.line_drive[0];
    res.sda_pull_low = st_next.line_drive[1];
    res.busy_res     = (st_next.step_index != '0);
    res.done_res     = done;
    res.ack_ok       = done & st_next.ack_good;
    res.read_data    = (done && st_next.ack_good && st_next.is_read) ?
                       st_next.shift_byte : 8'h00;
  end

  // Advance the state once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A finished STOP leaves the sequencer idle
  assert property (@(posedge clk) disable iff (rst)
    fire && res.done_res |=> st.step_index == '0)
    else $error("sequencer not idle after done");

  // A tick with no start operation keeps an idle sequencer idle
  assert property (@(posedge clk) disable iff (rst)
    fire && st.step_index == '0 && operation != OP_WRITE && operation != OP_READ
    |=> st.step_index == '0)
    else $error("idle sequencer left idle without a start");

  // Acknowledge status only comes with done
  assert property (@(posedge clk) disable iff (rst)
    res.ack_ok |-> res.done_res)
    else $error("ack_ok without done");

  // Both lines are released whenever the sequencer rests idle
  assert property (@(posedge clk) disable iff (rst)
    fire && !res.busy_res |=> st.line_drive == 2'b00)
    else $error("line held low while idle");
`endif

endmodule

`default_nettype wire

/* rtl/i2c_register_access_master.sv */
// Top level of the I2C register access master: input stage, sequencer, result stage.
//
//   channel  direction  tdata / tuser contents
//   s_axis   in         tuser: operation; tdata: reg_addr, write_data, sda_level
//   m_axis   out        tdata: scl, sda pull-low, busy, done, ack_ok, read_data
//   cfg      in         device_address (7 bits)
//
// One item moves through the input register, then the one-step sequencer logic
// into the result register; one item is taken every cycle while m_axis does not stall.
// The device address register is the only configuration state.
// Reset (rst, synchronous) leaves the sequencer idle with both lines released
// and the address at 0x68. A stall on m_axis holds the result and backs up
// into s_axis once the input register is full.
`default_nettype none

module i2c_register_access_master (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // reg_addr[7:0], write_data[15:8], sda_level[16]
  input  wire logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // scl_pull_low[0], sda_pull_low[1], busy_res[2],
                                          // done_res[3], ack_ok[4], read_data[12:5]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data
);
  import i2cram_pkg::*;

  logic        in_valid;
  logic [1:0]  in_operation;
  logic [7:0]  in_reg_addr;
  logic [7:0]  in_write_data;
  logic        in_sda_level;
  logic        fire;
  logic [6:0]  device_address;
  result_t     res;
  result_t     out_res;

  assign fire          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;
  assign cfg_ready     = 1'b1;

  // Hold the device address
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= ADDR_RESET;
    end else if (cfg_valid) begin
      device_address <= cfg_data;
    end
  end

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_operation  <= s_axis_tuser;
      in_reg_addr   <= s_axis_tdata[7:0];
      in_write_data <= s_axis_tdata[15:8];
      in_sda_level  <= s_axis_tdata[16];
    end
  end

  i2cram_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .operation      (in_operation),
    .reg_addr       (in_reg_addr),
    .write_data     (in_write_data),
    .sda_level      (in_sda_level),
    .device_address (device_address),
    .res            (res)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {3'b000, out_res};

endmodule

`default_nettype wire
